### src/pfp_pkg.sv
package pfp_pkg;

    // frame header bytes
    localparam logic [7:0] HDR0 = 8'hAA;
    localparam logic [7:0] HDR1 = 8'h55;

    // bytes counted outside the payload: two header bytes, length, checksum
    localparam int FRAME_OVERHEAD = 4;

    // default largest payload
    localparam int MAX_PAYLOAD_DEF = 5;

    // panel command codes
    localparam logic [7:0] CMD_WRITE_CLEAR = 8'h01;
    localparam logic [7:0] CMD_PAGE        = 8'h02;
    localparam logic [7:0] CMD_WORK        = 8'h03;
    localparam logic [7:0] CMD_MATERIAL    = 8'h06;
    localparam logic [7:0] CMD_MONEY       = 8'h07;
    localparam logic [7:0] CMD_REPORT_TH   = 8'h08;
    localparam logic [7:0] CMD_TH_FIRST    = 8'h09;
    localparam logic [7:0] CMD_TH_LAST     = 8'h0E;
    localparam logic [7:0] CMD_REPORT_LVL  = 8'hFE;
    localparam logic [7:0] CMD_LEVEL       = 8'hFF;

    localparam int NUM_THRESH = 6;

    typedef enum logic [1:0] {
        ST_RECEIVING = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_BAD_SUM   = 2'd2,
        ST_DROPPED   = 2'd3
    } frame_status_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_REPORT_TH    = 3'd1,
        ACT_REPORT_LEVEL = 3'd2,
        ACT_STORE_TH     = 3'd3,
        ACT_STORE_LEVEL  = 3'd4
    } action_t;

    // one result word
    typedef struct packed {
        logic [7:0]    threshold_value;
        logic [2:0]    threshold_index;
        action_t       action;
        logic [7:0]    level_value;
        logic [2:0]    money_write;
        logic          note_confirm;
        logic [1:0]    material_write;
        logic          mat_confirm;
        logic [1:0]    work_button;
        logic          write_request;
        logic [7:0]    page_number;
        frame_status_t frame_status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### src/panel_frame_parser.sv
// channel   dir  payload
// s_*       in   tdata[7:0] rx_byte
// m_*       out  tdata[41:0] result fields, zero filled to 48 bits
//
// one byte per cycle while s_tready is high: the byte is parsed against the frame
// state in the cycle it is accepted and its result lands in the output register
// the frame state and panel registers all clear on reset, output empty
// s_tready follows m_tready when a result is held, so a stalled output
// holds one result while the next byte waits at the input
module panel_frame_parser #(
    parameter int MAX_PAYLOAD = pfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_status[1:0], page_number[9:2], write_request[10],
    // work_button[12:11], mat_confirm[13], material_write[15:14],
    // note_confirm[16], money_write[19:17], level_value[27:20],
    // action[30:28], threshold_index[33:31], threshold_value[41:34]
    output logic [pfp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pfp_pkg::*;

    localparam int MAX_COUNT = MAX_PAYLOAD + FRAME_OVERHEAD;
    localparam int CW = $clog2(MAX_COUNT + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);
    localparam logic [CW-1:0] IDX_FIRST = CW'(0);
    localparam logic [CW-1:0] IDX_SECOND = CW'(1);
    localparam logic [CW-1:0] IDX_LENGTH = CW'(2);
    localparam logic [CW-1:0] IDX_CMD = CW'(3);
    localparam logic [CW-1:0] IDX_VALUE = CW'(4);
    localparam logic [CW-1:0] CNT_HDR = CW'(3);

    // frame state
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic [7:0]    length_reg, length_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    value_reg, value_next;
    logic [7:0]    sum_reg, sum_next;

    // panel registers
    logic [7:0] page_reg, page_next;
    logic       write_reg, write_next;
    logic [1:0] work_reg, work_next;
    logic       mat_btn_reg, mat_btn_next;
    logic [1:0] mat_wr_reg, mat_wr_next;
    logic       money_btn_reg, money_btn_next;
    logic [2:0] money_wr_reg, money_wr_next;
    logic [7:0] level_reg, level_next;
    logic [7:0] thresh_reg [NUM_THRESH];
    logic [7:0] thresh_next [NUM_THRESH];

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic          take;
    logic [CW-1:0] n;
    logic [8:0]    frame_len;
    logic          accepted;
    frame_status_t status;
    logic [7:0]    b;
    logic [2:0]    tidx;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    // header capture, frame tracking and checksum
    always_comb
    begin
        first_next  = (count_reg == IDX_FIRST)  ? b : first_reg;
        second_next = (count_reg == IDX_SECOND) ? b : second_reg;
        length_next = (count_reg == IDX_LENGTH) ? b : length_reg;
        cmd_next    = (count_reg == IDX_CMD)    ? b : cmd_reg;
        value_next  = (count_reg == IDX_VALUE)  ? b : value_reg;

        n         = count_reg + CW'(1);
        frame_len = {1'b0, length_next} + 9'(FRAME_OVERHEAD);
        accepted  = 1'b0;
        status    = ST_RECEIVING;
        count_next = n;
        sum_next   = sum_reg + b;

        if (n > CNT_MAX || first_next != HDR0)
        begin
            status     = ST_DROPPED;
            count_next = '0;
            sum_next   = '0;
        end
        else if (n > CNT_HDR && second_next != HDR1)
        begin
            status     = ST_DROPPED;
            count_next = '0;
            sum_next   = '0;
        end
        else if (n > CNT_HDR && 9'(n) >= frame_len)
        begin
            if (sum_reg == b)
            begin
                status   = ST_ACCEPTED;
                accepted = 1'b1;
            end
            else
            begin
                status = ST_BAD_SUM;
            end
            count_next = '0;
            sum_next   = '0;
        end
    end

    // command decode on an accepted frame
    always_comb
    begin
        page_next      = page_reg;
        write_next     = write_reg;
        work_next      = work_reg;
        mat_btn_next   = mat_btn_reg;
        mat_wr_next    = mat_wr_reg;
        money_btn_next = money_btn_reg;
        money_wr_next  = money_wr_reg;
        level_next     = level_reg;
        for (int i = 0; i < NUM_THRESH; i++)
        begin
            thresh_next[i] = thresh_reg[i];
        end
        tidx = 3'(cmd_next - CMD_TH_FIRST);
        out_next.frame_status    = status;
        out_next.action          = ACT_NONE;
        out_next.threshold_index = '0;
        out_next.threshold_value = '0;

        if (accepted)
        begin
            if (cmd_next >= CMD_TH_FIRST && cmd_next <= CMD_TH_LAST)
            begin
                thresh_next[tidx]        = value_next;
                out_next.action          = ACT_STORE_TH;
                out_next.threshold_index = tidx;
                out_next.threshold_value = value_next;
            end
            else
            begin
                unique case (cmd_next)
                    CMD_WRITE_CLEAR: write_next = 1'b0;
                    CMD_PAGE:
                    begin
                        page_next  = value_next;
                        write_next = 1'b1;
                    end
                    CMD_WORK:
                    begin
                        if (value_next == 8'd1 || value_next == 8'd2)
                        begin
                            work_next = value_next[1:0];
                        end
                    end
                    CMD_MATERIAL:
                    begin
                        if (value_next == 8'd1)
                        begin
                            mat_btn_next = 1'b1;
                        end
                        else if (value_next == 8'd2)
                        begin
                            mat_wr_next = 2'd1;
                        end
                        else if (value_next == 8'd3)
                        begin
                            mat_wr_next = 2'd2;
                        end
                        else
                        begin
                            mat_btn_next = 1'b0;
                        end
                    end
                    CMD_MONEY:
                    begin
                        if (value_next == 8'd1)
                        begin
                            money_btn_next = 1'b1;
                        end
                        else if (value_next >= 8'd2 && value_next <= 8'd5)
                        begin
                            money_wr_next = 3'(value_next - 8'd1);
                        end
                        else
                        begin
                            money_btn_next = 1'b0;
                        end
                    end
                    CMD_REPORT_TH:
                    begin
                        out_next.action          = ACT_REPORT_TH;
                        out_next.threshold_value = thresh_reg[0];
                    end
                    CMD_REPORT_LVL: out_next.action = ACT_REPORT_LEVEL;
                    CMD_LEVEL:
                    begin
                        level_next      = value_next;
                        out_next.action = ACT_STORE_LEVEL;
                    end
                    default: ;
                endcase
            end
        end

        out_next.page_number    = page_next;
        out_next.write_request  = write_next;
        out_next.work_button    = work_next;
        out_next.mat_confirm    = mat_btn_next;
        out_next.material_write = mat_wr_next;
        out_next.note_confirm   = money_btn_next;
        out_next.money_write    = money_wr_next;
        out_next.level_value    = level_next;
    end

    // output word valid
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            length_reg    <= '0;
            cmd_reg       <= '0;
            value_reg     <= '0;
            sum_reg       <= '0;
            page_reg      <= '0;
            write_reg     <= 1'b0;
            work_reg      <= '0;
            mat_btn_reg   <= 1'b0;
            mat_wr_reg    <= '0;
            money_btn_reg <= 1'b0;
            money_wr_reg  <= '0;
            level_reg     <= '0;
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thresh_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                count_reg     <= count_next;
                first_reg     <= first_next;
                second_reg    <= second_next;
                length_reg    <= length_next;
                cmd_reg       <= cmd_next;
                value_reg     <= value_next;
                sum_reg       <= sum_next;
                page_reg      <= page_next;
                write_reg     <= write_next;
                work_reg      <= work_next;
                mat_btn_reg   <= mat_btn_next;
                mat_wr_reg    <= mat_wr_next;
                money_btn_reg <= money_btn_next;
                money_wr_reg  <= money_wr_next;
                level_reg     <= level_next;
                for (int i = 0; i < NUM_THRESH; i++)
                begin
                    thresh_reg[i] <= thresh_next[i];
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule
